/* sv/source_byte_tokenizer_top_assert.svh */
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef SOURCE_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_BYTE_TOKENIZER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset
`define SBT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SBT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sbt_pkg.sv */
// Shared types and constants for the source byte tokenizer.
// No dependencies; used by sbt_scan, sbt_res_fifo and the top level.
package sbt_pkg;

	// Default content size limit in bytes
	localparam int unsigned MAX_TEXT_BYTES_DEF = 1048576;

	// Result buffer geometry
	localparam int RES_DEPTH = 4;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);

	// Input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} tok_in_t;

	// Result beat
	typedef struct packed {
		logic [19:0] token_offset;
		logic [20:0] token_length;
		logic        run_last;
		logic        position_overflow;
	} tok_out_t;

	// Results produced by one input beat, compacted into ent0 first
	typedef struct packed {
		logic [1:0] n;
		tok_out_t   ent0;
		tok_out_t   ent1;
	} res_push_t;

endpackage

/* sv/source_byte_tokenizer_top.sv */
// Top level of the source byte tokenizer.
// Depends on sbt_pkg, sbt_scan and sbt_res_fifo.
//
// Usage:
//   src channel: one text byte per beat (src_data), end_of_text on the final
//     byte of the content. Token boundaries come out on the tok channel as
//     offset/length beats; run_last marks the last token caused by one byte.
//   Each byte yields zero, one or two tokens. Results are registered in the
//   result buffer as the byte is taken and go out on tok behind earlier ones.
//   Throughput: one byte per cycle while the four-entry result buffer has
//   room for two more beats; src_ready drops when it does not, so a byte
//   that yields two tokens every cycle runs at half rate against a sink
//   that takes one beat per cycle.
//   A stalled tok side fills the result buffer and then holds off src; no
//   result is dropped.
//   After the final byte the scanner returns to its reset state, so the next
//   byte starts new content at offset zero.
//   Reset (arst_n low) clears the scanner and empties the result buffer.
//   Positions beyond MAX_TEXT_BYTES-1 saturate and set position_overflow.
module source_byte_tokenizer_top #(
	parameter int unsigned MAX_TEXT_BYTES = sbt_pkg::MAX_TEXT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  sbt_pkg::tok_in_t   src_data,
	output logic               tok_valid,
	input  logic               tok_ready,
	output sbt_pkg::tok_out_t  tok_data
);

	sbt_pkg::res_push_t push;
	logic               room;
	logic               accept;

	// Byte taken when the buffer can absorb its results
	assign src_ready = room;
	assign accept    = src_valid && room;

	sbt_scan #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (src_data),
		.push  (push)
	);

	sbt_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_data (tok_data)
	);

endmodule

/* sv/sbt_scan.sv */
// Scanner state and per-byte token decision for the source byte tokenizer.
// Depends on sbt_pkg and source_byte_tokenizer_top_assert.svh.
`include "source_byte_tokenizer_top_assert.svh"

module sbt_scan #(
	parameter int unsigned MAX_TEXT_BYTES = sbt_pkg::MAX_TEXT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  sbt_pkg::tok_in_t    item,
	output sbt_pkg::res_push_t  push
);

	localparam int POS_W = $clog2(MAX_TEXT_BYTES);
	localparam int LEN_W = $clog2(MAX_TEXT_BYTES + 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_BYTES - 1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TEXT_BYTES);

	// Scan modes
	localparam logic [2:0] M_REG   = 3'd0;
	localparam logic [2:0] M_OP    = 3'd1;
	localparam logic [2:0] M_SQ    = 3'd2;
	localparam logic [2:0] M_SQE   = 3'd3;
	localparam logic [2:0] M_DQ    = 3'd4;
	localparam logic [2:0] M_DQE   = 3'd5;
	localparam logic [2:0] M_LINE  = 3'd6;
	localparam logic [2:0] M_BLOCK = 3'd7;

	// Character codes
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	// Scanner state
	logic [2:0]       mode_q;
	logic [7:0]       prev_q;
	logic [POS_W-1:0] pstart_q;
	logic [LEN_W-1:0] plen_q;
	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic             lim_q;

	logic [7:0]       b;
	logic             is_sep, is_sq, is_dq, is_op, is_eol;
	logic             reg_pre, reg_post;
	logic [2:0]       reg_mode;
	logic             pre, post;
	logic [2:0]       mode_d;
	logic [7:0]       prev_d;
	logic             ov0, ov1, sat, emit0, emit1;
	logic [LEN_W-1:0] base_len, add_len;
	logic [POS_W-1:0] add_start;
	sbt_pkg::tok_out_t res0, res1;

	assign b = item.text_byte;

	// Byte classes
	always_comb begin
		is_sep = 1'b0;
		is_sq  = 1'b0;
		is_dq  = 1'b0;
		is_op  = 1'b0;
		case (b)
			CH_LF, CH_CR, CH_TAB, CH_SPACE, CH_LBRACE, CH_RBRACE,
			CH_LPAREN, CH_RPAREN, CH_EQ, CH_COMMA, CH_SEMI: is_sep = 1'b1;
			CH_SQUOTE: is_sq = 1'b1;
			CH_DQUOTE: is_dq = 1'b1;
			CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR,
			CH_PIPE, CH_AMP, CH_CARET, CH_TILDE: is_op = 1'b1;
			default: ;
		endcase
		is_eol = (b == CH_CR) || (b == CH_LF);
	end

	// Plain code handling of one byte
	always_comb begin
		reg_pre  = is_sep || is_sq || is_dq || is_op;
		reg_post = is_sep;
		if (is_sq) begin
			reg_mode = M_SQ;
		end else if (is_dq) begin
			reg_mode = M_DQ;
		end else if (is_op) begin
			reg_mode = M_OP;
		end else begin
			reg_mode = M_REG;
		end
	end

	// Mode step: every byte joins a token; pre flushes before it, post after it
	always_comb begin
		pre    = 1'b0;
		post   = 1'b0;
		mode_d = mode_q;
		prev_d = b;
		unique case (mode_q)
			M_REG: begin
				pre    = reg_pre;
				post   = reg_post;
				mode_d = reg_mode;
			end
			M_OP: begin
				if (b == CH_EQ || (prev_q == CH_PLUS && b == CH_PLUS) ||
				    (prev_q == CH_MINUS && b == CH_MINUS)) begin
					post   = 1'b1;
					mode_d = M_REG;
				end else if (prev_q == CH_SLASH && b == CH_SLASH) begin
					mode_d = M_LINE;
				end else if (prev_q == CH_SLASH && b == CH_STAR) begin
					// opening star cannot close the comment
					mode_d = M_BLOCK;
					prev_d = 8'h00;
				end else begin
					// operator ends; byte is taken again as plain code
					pre    = 1'b1;
					post   = reg_post;
					mode_d = reg_mode;
				end
			end
			M_SQ: begin
				if (b == CH_BSLASH) begin
					mode_d = M_SQE;
				end else if (b == CH_SQUOTE) begin
					post   = 1'b1;
					mode_d = M_REG;
				end
			end
			M_SQE: mode_d = M_SQ;
			M_DQ: begin
				if (b == CH_BSLASH) begin
					mode_d = M_DQE;
				end else if (b == CH_DQUOTE) begin
					post   = 1'b1;
					mode_d = M_REG;
				end
			end
			M_DQE: mode_d = M_DQ;
			M_LINE: begin
				if (is_eol) begin
					pre    = 1'b1;
					post   = 1'b1;
					mode_d = M_REG;
				end
			end
			M_BLOCK: begin
				if (prev_q == CH_STAR && b == CH_SLASH) begin
					post   = 1'b1;
					mode_d = M_REG;
				end
			end
		endcase
	end

	// Token bookkeeping and result beats
	always_comb begin
		ov0       = ovf_q || lim_q;
		emit0     = pre && (plen_q != '0);
		base_len  = pre ? '0 : plen_q;
		add_start = (base_len == '0) ? pos_q : pstart_q;
		sat       = (base_len == LEN_MAX);
		add_len   = sat ? base_len : base_len + LEN_W'(1);
		ov1       = ov0 || sat;
		emit1     = post || item.end_of_text;

		res0.token_offset      = 20'(pstart_q);
		res0.token_length      = 21'(plen_q);
		res0.run_last          = !emit1;
		res0.position_overflow = ov0;
		res1.token_offset      = 20'(add_start);
		res1.token_length      = 21'(add_len);
		res1.run_last          = 1'b1;
		res1.position_overflow = ov1;

		push.ent0 = emit0 ? res0 : res1;
		push.ent1 = res1;
		if (!accept) begin
			push.n = 2'd0;
		end else begin
			push.n = 2'({1'b0, emit0} + {1'b0, emit1});
		end
	end

	// State update; final byte returns the scanner to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_REG;
			prev_q   <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			pos_q    <= '0;
			ovf_q    <= 1'b0;
			lim_q    <= 1'b0;
		end else if (accept) begin
			if (item.end_of_text) begin
				mode_q   <= M_REG;
				prev_q   <= '0;
				pstart_q <= '0;
				plen_q   <= '0;
				pos_q    <= '0;
				ovf_q    <= 1'b0;
				lim_q    <= 1'b0;
			end else begin
				mode_q   <= mode_d;
				prev_q   <= prev_d;
				pstart_q <= add_start;
				plen_q   <= post ? '0 : add_len;
				pos_q    <= (pos_q == POS_LAST) ? pos_q : pos_q + POS_W'(1);
				ovf_q    <= ov1;
				lim_q    <= lim_q || (pos_q == POS_LAST);
			end
		end
	end

	`SBT_ASSERT_NEXT(a_eot_clears, clk, arst_n, accept && item.end_of_text,
		mode_q == M_REG && pos_q == '0 && plen_q == '0 && !ovf_q && !lim_q,
		"scanner not cleared after final byte")
	`SBT_ASSERT_IMPLIES(a_lim_saturated, clk, arst_n, lim_q, pos_q == POS_LAST,
		"limit flag set but position not saturated")
	`SBT_ASSERT_IMPLIES(a_len_bound, clk, arst_n, plen_q != '0,
		plen_q <= LEN_MAX && mode_q != M_REG || plen_q <= LEN_MAX,
		"pending length beyond content limit")

endmodule

/* sv/sbt_res_fifo.sv */
// Result buffer: takes up to two result beats per cycle, hands out one.
// Depends on sbt_pkg and source_byte_tokenizer_top_assert.svh.
`include "source_byte_tokenizer_top_assert.svh"

module sbt_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  sbt_pkg::res_push_t  push,
	output logic                room,
	output logic                tok_valid,
	input  logic                tok_ready,
	output sbt_pkg::tok_out_t   tok_data
);

	sbt_pkg::tok_out_t              mem_q [sbt_pkg::RES_DEPTH];
	logic [sbt_pkg::PTR_W-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr1;
	logic [sbt_pkg::CNT_W-1:0]      cnt_q;
	logic                           pop;

	// Room for a worst-case beat pair
	assign room      = cnt_q <= sbt_pkg::CNT_W'(sbt_pkg::RES_DEPTH - 2);
	assign tok_valid = cnt_q != '0;
	assign tok_data  = mem_q[rd_ptr_q];
	assign pop       = tok_valid && tok_ready;
	assign wr_ptr1   = wr_ptr_q + sbt_pkg::PTR_W'(1);

	// Storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.ent0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr1] <= push.ent1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sbt_pkg::PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sbt_pkg::PTR_W'(1);
			end
			cnt_q <= cnt_q + sbt_pkg::CNT_W'(push.n) - sbt_pkg::CNT_W'(pop);
		end
	end

	`SBT_ASSERT_ALWAYS(a_cnt_range, clk, arst_n,
		cnt_q <= sbt_pkg::CNT_W'(sbt_pkg::RES_DEPTH), "result buffer overfilled")
	`SBT_ASSERT_IMPLIES(a_push_room, clk, arst_n, push.n != 2'd0, room,
		"results pushed without room")
	`SBT_ASSERT_NEXT(a_tok_hold, clk, arst_n, tok_valid && !tok_ready,
		tok_valid && $stable(tok_data), "result beat changed while stalled")

endmodule

/* tb/source_byte_tokenizer_top_tb.sv */
// Self-checking testbench for source_byte_tokenizer_top: directed and random byte streams
// are scored against a behavioral scanner kept in the bench.
// Depends on sbt_pkg and the tokenizer RTL; the block is built with a 256-byte content limit.
module source_byte_tokenizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Content limit in bytes for the block under test
	localparam int unsigned TEXT_LIMIT = 256;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_BSL = 8'h5C;

	typedef enum logic [2:0] {
		SCAN_CODE, SCAN_OPER, SCAN_SQUOTE, SCAN_SQUOTE_ESC,
		SCAN_DQUOTE, SCAN_DQUOTE_ESC, SCAN_LINE_CMT, SCAN_BLOCK_CMT
	} scan_mode_e;

	typedef enum logic [2:0] {
		LEX_IDENT, LEX_SEPARATOR, LEX_OPERATOR, LEX_STRING,
		LEX_LINE_CMT, LEX_BLOCK_CMT, LEX_NOISE
	} lex_kind_e;

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	logic               src_ready;
	sbt_pkg::tok_in_t   src_data;
	logic               tok_valid;
	logic               tok_ready;
	sbt_pkg::tok_out_t  tok_data;

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned items_sent;
	int unsigned error_count;

	// Scanner state mirrored in the bench
	scan_mode_e  scan_mode;
	logic [7:0]  scan_prev;
	logic [19:0] scan_start;
	int unsigned scan_len;
	int unsigned scan_pos;
	int unsigned scan_cur;
	logic        scan_ovf;
	logic        scan_at_limit;

	sbt_pkg::tok_out_t step_tokens[$];
	sbt_pkg::tok_out_t boundary_q[$];

	source_byte_tokenizer_top #(
		.MAX_TEXT_BYTES(TEXT_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data (src_data),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_data (tok_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- scanner model

	function automatic void reset_scanner();
		scan_mode     = SCAN_CODE;
		scan_prev     = 8'h00;
		scan_start    = '0;
		scan_len      = 0;
		scan_pos      = 0;
		scan_ovf      = 1'b0;
		scan_at_limit = 1'b0;
	endfunction

	// Close the pending token, if any; at most three per byte
	function automatic void emit_token();
		sbt_pkg::tok_out_t t;
		if (scan_len != 0 && step_tokens.size() < 3) begin
			t.token_offset      = scan_start;
			t.token_length      = scan_len[20:0];
			t.run_last          = 1'b0;
			t.position_overflow = scan_ovf;
			step_tokens.push_back(t);
		end
		scan_len = 0;
	endfunction

	// Append the current byte to the pending token, saturating the length
	function automatic void grow_token();
		if (scan_len == 0)
			scan_start = scan_cur[19:0];
		if (scan_len < TEXT_LIMIT)
			scan_len++;
		else
			scan_ovf = 1'b1;
	endfunction

	function automatic void scan_code_byte(input logic [7:0] b);
		case (b)
			CH_LF, CH_CR, CH_TAB, " ", "{", "}", "(", ")", "=", ",", ";": begin
				emit_token();
				grow_token();
				emit_token();
			end
			CH_SQ: begin
				emit_token();
				grow_token();
				scan_mode = SCAN_SQUOTE;
			end
			CH_DQ: begin
				emit_token();
				grow_token();
				scan_mode = SCAN_DQUOTE;
			end
			"+", "-", "/", "*", "|", "&", "^", "~": begin
				// pending identifier goes out before the operator starts
				emit_token();
				grow_token();
				scan_mode = SCAN_OPER;
			end
			default: grow_token();
		endcase
	endfunction

	// Work out the tokens caused by one accepted beat and queue them
	function automatic void scan_byte(input sbt_pkg::tok_in_t beat);
		logic [7:0] b;
		logic [7:0] prev;
		logic [7:0] next_prev;
		b         = beat.text_byte;
		prev      = scan_prev;
		next_prev = b;
		step_tokens.delete();
		if (scan_at_limit)
			scan_ovf = 1'b1;
		scan_cur = scan_pos;

		case (scan_mode)
			SCAN_CODE: scan_code_byte(b);
			SCAN_OPER: begin
				if (b == "=" || (prev == "+" && b == "+") || (prev == "-" && b == "-")) begin
					grow_token();
					emit_token();
					scan_mode = SCAN_CODE;
				end else if (prev == "/" && b == "/") begin
					grow_token();
					scan_mode = SCAN_LINE_CMT;
				end else if (prev == "/" && b == "*") begin
					grow_token();
					scan_mode = SCAN_BLOCK_CMT;
					// opening star must not close the comment
					next_prev = 8'h00;
				end else begin
					// byte does not extend the operator: flush, then treat as code
					emit_token();
					scan_mode = SCAN_CODE;
					scan_code_byte(b);
				end
			end
			SCAN_SQUOTE, SCAN_DQUOTE: begin
				grow_token();
				if (b == CH_BSL) begin
					if (scan_mode == SCAN_SQUOTE)
						scan_mode = SCAN_SQUOTE_ESC;
					else
						scan_mode = SCAN_DQUOTE_ESC;
				end else if ((scan_mode == SCAN_SQUOTE && b == CH_SQ) ||
						(scan_mode == SCAN_DQUOTE && b == CH_DQ)) begin
					emit_token();
					scan_mode = SCAN_CODE;
				end
			end
			SCAN_SQUOTE_ESC: begin
				grow_token();
				scan_mode = SCAN_SQUOTE;
			end
			SCAN_DQUOTE_ESC: begin
				grow_token();
				scan_mode = SCAN_DQUOTE;
			end
			SCAN_LINE_CMT: begin
				if (b == CH_CR || b == CH_LF) begin
					emit_token();
					grow_token();
					emit_token();
					scan_mode = SCAN_CODE;
				end else begin
					grow_token();
				end
			end
			default: begin
				grow_token();
				if (prev == "*" && b == "/") begin
					emit_token();
					scan_mode = SCAN_CODE;
				end
			end
		endcase
		scan_prev = next_prev;

		// position saturates at the last valid offset
		if (scan_pos < TEXT_LIMIT - 1)
			scan_pos++;
		else
			scan_at_limit = 1'b1;

		if (beat.end_of_text) begin
			emit_token();
			reset_scanner();
		end

		if (step_tokens.size() > 0)
			step_tokens[$].run_last = 1'b1;
		foreach (step_tokens[i])
			boundary_q.push_back(step_tokens[i]);
	endfunction

	// ---------------------------------------------------------------- scoring

	function automatic void count_failure(input string msg);
		if (error_count < 10)
			$display("%0t: %s", $realtime, msg);
		error_count++;
	endfunction

	function automatic void check_token(input sbt_pkg::tok_out_t want,
			input sbt_pkg::tok_out_t got);
		if (got.token_offset !== want.token_offset)
			count_failure($sformatf("token_offset: expected %0d, got %0d",
				want.token_offset, got.token_offset));
		if (got.token_length !== want.token_length)
			count_failure($sformatf("token_length: expected %0d, got %0d",
				want.token_length, got.token_length));
		if (got.run_last !== want.run_last)
			count_failure($sformatf("run_last: expected %0b, got %0b",
				want.run_last, got.run_last));
		if (got.position_overflow !== want.position_overflow)
			count_failure($sformatf("position_overflow: expected %0b, got %0b",
				want.position_overflow, got.position_overflow));
	endfunction

	// Result side: random back-pressure, check every beat taken
	always @(negedge clk)
		tok_ready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready) begin
			if (boundary_q.size() == 0)
				count_failure($sformatf("token at offset %0d, length %0d with none expected",
					tok_data.token_offset, tok_data.token_length));
			else
				check_token(boundary_q.pop_front(), tok_data);
		end
	end

	// ---------------------------------------------------------------- stimulus

	// Drive one beat, with random idle cycles ahead of it, and score it on acceptance
	task automatic send_byte(input logic [7:0] b, input logic eot);
		sbt_pkg::tok_in_t beat;
		beat.text_byte   = b;
		beat.end_of_text = eot;
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= beat;
		do
			@(posedge clk);
		while (!src_ready);
		scan_byte(beat);
		items_sent++;
	endtask

	task automatic send_text(input string s, input logic eot);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot && (i == s.len() - 1));
	endtask

	// Single-byte tokens, byte extremes and content of one byte
	task automatic test_separators();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("x \t{}()=,;\015\n", 1'b1);
		send_byte("z", 1'b1);
	endtask

	// Compound operators, identifier before operator, non-extending byte
	task automatic test_operators();
		send_text("ab+=c++d--e/f~g|&^*", 1'b1);
	endtask

	// Both quote styles with escapes, then content ending inside a string
	task automatic test_quotes();
		send_text("'a\\'b'\"c\\\"\"", 1'b0);
		send_text("\"ab", 1'b1);
	endtask

	// Line comment ends before CR/LF; slash-star-slash keeps the block open
	task automatic test_comments();
		send_text("//c\015x//\n/*/ *x*/", 1'b0);
		send_text("/*a", 1'b1);
		send_text("y//q", 1'b1);
	endtask

	// One lexeme-shaped run of random content, occasionally cut by end_of_text
	task automatic send_random_lexeme();
		logic [7:0] lex[$];
		logic [7:0] op;
		logic [7:0] quote;
		int         n;
		string      seps;
		string      ops;
		string      mix;
		string      alnum;
		seps  = " \t\015\n{}()=,;";
		ops   = "+-/*|&^~";
		mix   = "ab_9 *\\/'\"=\n+";
		alnum = "abcxyz_019AZ";
		n     = $urandom_range(1, 6);
		case (lex_kind_e'($urandom_range(0, 6)))
			LEX_IDENT:
				repeat (n) lex.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
			LEX_SEPARATOR:
				lex.push_back(seps[$urandom_range(0, seps.len() - 1)]);
			LEX_OPERATOR: begin
				op = ops[$urandom_range(0, ops.len() - 1)];
				lex.push_back(op);
				case ($urandom_range(0, 3))
					0: lex.push_back("=");
					1: lex.push_back(op);
					2: lex.push_back(mix[$urandom_range(0, mix.len() - 1)]);
					default: ;
				endcase
			end
			LEX_STRING: begin
				quote = ($urandom_range(0, 1) == 0) ? CH_SQ : CH_DQ;
				lex.push_back(quote);
				repeat (n) lex.push_back(mix[$urandom_range(0, mix.len() - 1)]);
				lex.push_back(quote);
			end
			LEX_LINE_CMT: begin
				lex.push_back("/");
				lex.push_back("/");
				repeat (n) lex.push_back(mix[$urandom_range(0, mix.len() - 1)]);
				lex.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
			end
			LEX_BLOCK_CMT: begin
				lex.push_back("/");
				lex.push_back("*");
				repeat (n) lex.push_back(mix[$urandom_range(0, mix.len() - 1)]);
				lex.push_back("*");
				lex.push_back("/");
			end
			default:
				repeat (n) lex.push_back(8'($urandom_range(0, 255)));
		endcase
		foreach (lex[i])
			send_byte(lex[i], $urandom_range(0, 39) == 0);
	endtask

	task automatic test_random_text(input int unsigned n);
		int unsigned first;
		first = items_sent;
		while (items_sent - first < n)
			send_random_lexeme();
		send_byte(";", 1'b1);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		src_valid     = 1'b0;
		src_data      = '0;
		tok_ready     = 1'b0;
		src_idle_pct  = 27;
		sink_idle_pct = 74;
		items_sent    = 0;
		error_count   = 0;
		reset_scanner();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_separators();
		test_operators();
		test_quotes();
		test_comments();
		test_random_text(35);

		src_idle_pct  = 74;
		sink_idle_pct = 27;
		test_random_text(35);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_text(35);

		@(negedge clk);
		src_valid <= 1'b0;
		while (boundary_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
